// ----- src/assert_macros.svh -----
// Assertion macros used by the top level of the acknowledgement retry table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checks a property on every rising clock edge outside reset.
`define ART_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition never holds outside reset.
`define ART_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ART_ASSERT(lbl, clk, rst_n, prop, msg)
`define ART_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// ----- src/art_pkg.sv -----
// Types and constants of the acknowledgement retry table.
package art_pkg;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETRIES = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_WAIT    = 8'd1;

    localparam logic [3:0] RST_MAX_RETRIES = 4'd3;
    localparam logic [7:0] RST_ACK_WAIT    = 8'd3;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_ACK   = 2'd1,
        OP_QUERY = 2'd2,
        OP_TICK  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        KIND_DONE   = 3'd0,
        KIND_RETX   = 3'd1,
        KIND_ACK_OK = 3'd2,
        KIND_NO_ACK = 3'd3,
        KIND_QUERY  = 3'd4,
        KIND_ADDED  = 3'd5,
        KIND_FULL   = 3'd6
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_ADD  = 2'd1,
        ST_SCAN = 2'd2,
        ST_PROC = 2'd3
    } state_t;

    typedef struct packed {
        logic [7:0]  handle;
        logic [7:0]  frame;
        logic [7:0]  counter;
        logic [15:0] cluster;
        logic [7:0]  endpoint;
        logic [3:0]  retries;
        logic [7:0]  timer;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Decision of the entry unit for the entry under inspection.
    typedef struct packed {
        logic   emit;
        kind_t  kind;
        logic   keep;
        logic   hit;
        entry_t upd;
    } act_t;

endpackage

// ----- src/art_if.sv -----
// Request, response and configuration channel interfaces of the retry table.
interface art_req_if import art_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [7:0]  handle;
    logic [7:0]  frame_ref;
    logic [7:0]  frame_counter;
    logic [15:0] cluster;
    logic [7:0]  endpoint;

    modport source (output valid, output op, output handle, output frame_ref,
                    output frame_counter, output cluster, output endpoint,
                    input ready);
    modport sink (input valid, input op, input handle, input frame_ref,
                  input frame_counter, input cluster, input endpoint,
                  output ready);
endinterface

interface art_rsp_if import art_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [7:0]  out_handle;
    logic [7:0]  out_frame_ref;
    logic [7:0]  out_counter;
    logic [15:0] out_cluster;
    logic [7:0]  out_endpoint;
    logic        found;
    logic        last;

    modport source (output valid, output kind, output out_handle, output out_frame_ref,
                    output out_counter, output out_cluster, output out_endpoint,
                    output found, output last, input ready);
    modport sink (input valid, input kind, input out_handle, input out_frame_ref,
                  input out_counter, input out_cluster, input out_endpoint,
                  input found, input last, output ready);
endinterface

interface art_cfg_if import art_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ----- src/art_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module art_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                clk,
    input  logic                                we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                    wdata,
    input  logic                                re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                    rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/art_entry_unit.sv -----
// Shared per-entry unit: key compare, timer aging and retry countdown.
module art_entry_unit import art_pkg::*; (
    input  op_t         op,
    input  entry_t      ent,
    input  logic [7:0]  key_handle,
    input  logic [7:0]  key_counter,
    input  logic [15:0] key_cluster,
    input  logic [7:0]  key_endpoint,
    input  logic [7:0]  ack_wait,
    output act_t        act
);

    logic [3:0] retries_dec;

    assign retries_dec = ent.retries - 4'd1;

    always_comb
    begin
        act.emit = 1'b0;
        act.kind = KIND_DONE;
        act.keep = 1'b1;
        act.hit  = 1'b0;
        act.upd  = ent;
        case (op)
            OP_ACK:
            begin
                if (ent.counter == key_counter && ent.cluster == key_cluster &&
                    ent.endpoint == key_endpoint)
                begin
                    act.emit = 1'b1;
                    act.kind = KIND_ACK_OK;
                    act.keep = 1'b0;
                end
            end
            OP_QUERY:
            begin
                if (ent.handle == key_handle)
                begin
                    act.emit = 1'b1;
                    act.kind = KIND_QUERY;
                    act.hit  = 1'b1;
                end
            end
            OP_TICK:
            begin
                if (ent.timer == 8'd0)
                begin
                    act.emit        = 1'b1;
                    act.upd.retries = retries_dec;
                    act.upd.timer   = ack_wait;
                    if (retries_dec != 4'd0)
                    begin
                        act.kind = KIND_RETX;
                    end
                    else
                    begin
                        act.kind = KIND_NO_ACK;
                        act.keep = 1'b0;
                    end
                end
                else
                begin
                    act.upd.timer = ent.timer - 8'd1;
                end
            end
            default:
            begin
                act.emit = 1'b0;
            end
        endcase
    end

endmodule

// ----- src/ack_retry_table.sv -----
// Top level of the acknowledgement retry table: sequencer, entry store and response register.
// The table keeps up to TABLE_DEPTH frames in insertion order in a RAM and
// answers one request at a time; ready is low while a request is worked on.
// An add appends the new entry behind the last one unless the table is full; a query
// walks the entries up to the first handle match. An acknowledgement or a tick walks
// them all: each entry is read from the RAM in ST_SCAN (registered read), then
// judged by the single entry unit in ST_PROC and written back at the write pointer,
// so the RAM port and the shared unit set the pace. Removed entries are squeezed
// out during the same pass by a separate write pointer that trails the read
// pointer. A result that finds the response register still full holds the
// walk until it drains. The entry store needs no clearing after reset.
// Configuration writes are taken at any time and are always ready.
`include "assert_macros.svh"

module ack_retry_table import art_pkg::*; #(
    parameter int TABLE_DEPTH = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    art_req_if.sink       req,
    art_rsp_if.source     rsp,
    art_cfg_if.sink       cfg
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);

    state_t        state_reg, state_next;
    op_t           op_reg, op_next;
    logic [7:0]    handle_reg, handle_next;
    logic [7:0]    frame_reg, frame_next;
    logic [7:0]    counter_reg, counter_next;
    logic [15:0]   cluster_reg, cluster_next;
    logic [7:0]    endpoint_reg, endpoint_next;
    logic [CW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic [3:0]    max_retries_reg;
    logic [7:0]    ack_wait_reg;

    logic          rsp_valid_reg, rsp_valid_next;
    kind_t         rsp_kind_reg, rsp_kind_next;
    logic [7:0]    rsp_handle_reg, rsp_handle_next;
    logic [7:0]    rsp_frame_reg, rsp_frame_next;
    logic [7:0]    rsp_counter_reg, rsp_counter_next;
    logic [15:0]   rsp_cluster_reg, rsp_cluster_next;
    logic [7:0]    rsp_endpoint_reg, rsp_endpoint_next;
    logic          rsp_found_reg, rsp_found_next;
    logic          rsp_last_reg, rsp_last_next;
    logic          emit;
    logic          out_free;

    logic          ram_we;
    logic          ram_re;
    logic [AW-1:0] ram_waddr;
    entry_t        ram_wdata;
    entry_t        ram_rdata;
    act_t          act;

    art_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rd_ptr_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    art_entry_unit u_entry (
        .op           (op_reg),
        .ent          (ram_rdata),
        .key_handle   (handle_reg),
        .key_counter  (counter_reg),
        .key_cluster  (cluster_reg),
        .key_endpoint (endpoint_reg),
        .ack_wait     (ack_wait_reg),
        .act          (act)
    );

    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;

    always_comb
    begin
        state_next        = state_reg;
        op_next           = op_reg;
        handle_next       = handle_reg;
        frame_next        = frame_reg;
        counter_next      = counter_reg;
        cluster_next      = cluster_reg;
        endpoint_next     = endpoint_reg;
        rd_ptr_next       = rd_ptr_reg;
        wr_ptr_next       = wr_ptr_reg;
        count_next        = count_reg;
        emit              = 1'b0;
        rsp_kind_next     = KIND_DONE;
        rsp_handle_next   = 8'd0;
        rsp_frame_next    = 8'd0;
        rsp_counter_next  = 8'd0;
        rsp_cluster_next  = 16'd0;
        rsp_endpoint_next = 8'd0;
        rsp_found_next    = 1'b0;
        rsp_last_next     = 1'b1;
        ram_we            = 1'b0;
        ram_re            = 1'b0;
        ram_waddr         = wr_ptr_reg[AW-1:0];
        ram_wdata         = act.upd;
        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    op_next       = op_t'(req.op);
                    handle_next   = req.handle;
                    frame_next    = req.frame_ref;
                    counter_next  = req.frame_counter;
                    cluster_next  = req.cluster;
                    endpoint_next = req.endpoint;
                    rd_ptr_next   = '0;
                    wr_ptr_next   = '0;
                    state_next    = (op_t'(req.op) == OP_ADD) ? ST_ADD : ST_SCAN;
                end
            end
            ST_ADD:
            begin
                if (out_free)
                begin
                    emit              = 1'b1;
                    rsp_handle_next   = handle_reg;
                    rsp_frame_next    = frame_reg;
                    rsp_counter_next  = counter_reg;
                    rsp_cluster_next  = cluster_reg;
                    rsp_endpoint_next = endpoint_reg;
                    if (count_reg == FULL_COUNT)
                    begin
                        rsp_kind_next = KIND_FULL;
                    end
                    else
                    begin
                        rsp_kind_next      = KIND_ADDED;
                        ram_we             = 1'b1;
                        ram_waddr          = count_reg[AW-1:0];
                        ram_wdata.handle   = handle_reg;
                        ram_wdata.frame    = frame_reg;
                        ram_wdata.counter  = counter_reg;
                        ram_wdata.cluster  = cluster_reg;
                        ram_wdata.endpoint = endpoint_reg;
                        ram_wdata.retries  = max_retries_reg;
                        ram_wdata.timer    = ack_wait_reg;
                        count_next         = count_reg + 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (rd_ptr_reg == count_reg)
                begin
                    // End of the walk: a miss answer for a query, a done marker otherwise.
                    if (out_free)
                    begin
                        emit = 1'b1;
                        if (op_reg == OP_QUERY)
                        begin
                            rsp_kind_next   = KIND_QUERY;
                            rsp_handle_next = handle_reg;
                        end
                        else
                        begin
                            count_next = wr_ptr_reg;
                        end
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    ram_re     = 1'b1;
                    state_next = ST_PROC;
                end
            end
            ST_PROC:
            begin
                if (!act.emit || out_free)
                begin
                    if (act.emit)
                    begin
                        emit              = 1'b1;
                        rsp_kind_next     = act.kind;
                        rsp_handle_next   = ram_rdata.handle;
                        rsp_frame_next    = ram_rdata.frame;
                        rsp_counter_next  = ram_rdata.counter;
                        rsp_cluster_next  = ram_rdata.cluster;
                        rsp_endpoint_next = ram_rdata.endpoint;
                        rsp_found_next    = act.hit;
                        rsp_last_next     = act.hit;
                    end
                    if (op_reg != OP_QUERY && act.keep)
                    begin
                        ram_we      = 1'b1;
                        wr_ptr_next = wr_ptr_reg + 1'b1;
                    end
                    rd_ptr_next = rd_ptr_reg + 1'b1;
                    state_next  = act.hit ? ST_IDLE : ST_SCAN;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        rsp_valid_next = emit || (rsp_valid_reg && !rsp.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_ptr_reg    <= rd_ptr_next;
            wr_ptr_reg    <= wr_ptr_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        handle_reg   <= handle_next;
        frame_reg    <= frame_next;
        counter_reg  <= counter_next;
        cluster_reg  <= cluster_next;
        endpoint_reg <= endpoint_next;
        if (emit)
        begin
            rsp_kind_reg     <= rsp_kind_next;
            rsp_handle_reg   <= rsp_handle_next;
            rsp_frame_reg    <= rsp_frame_next;
            rsp_counter_reg  <= rsp_counter_next;
            rsp_cluster_reg  <= rsp_cluster_next;
            rsp_endpoint_reg <= rsp_endpoint_next;
            rsp_found_reg    <= rsp_found_next;
            rsp_last_reg     <= rsp_last_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_retries_reg <= RST_MAX_RETRIES;
            ack_wait_reg    <= RST_ACK_WAIT;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == CFG_MAX_RETRIES)
            begin
                max_retries_reg <= cfg.data[3:0];
            end
            else if (cfg.index == CFG_ACK_WAIT)
            begin
                ack_wait_reg <= cfg.data;
            end
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.kind          = rsp_kind_reg;
    assign rsp.out_handle    = rsp_handle_reg;
    assign rsp.out_frame_ref = rsp_frame_reg;
    assign rsp.out_counter   = rsp_counter_reg;
    assign rsp.out_cluster   = rsp_cluster_reg;
    assign rsp.out_endpoint  = rsp_endpoint_reg;
    assign rsp.found         = rsp_found_reg;
    assign rsp.last          = rsp_last_reg;

    // The compacting write pointer never overtakes the read pointer.
    `ART_ASSERT(a_wr_behind_rd, clk, rst_n, (wr_ptr_reg <= rd_ptr_reg), "write pointer ahead of read")
    `ART_ASSERT(a_count_bound, clk, rst_n, (count_reg <= FULL_COUNT), "entry count beyond depth")
    `ART_ASSERT(a_busy_after_req, clk, rst_n, (req.valid && req.ready) |=> !req.ready, "ready after request")
    `ART_NEVER(a_we_state, clk, rst_n, ram_we && state_reg != ST_PROC && state_reg != ST_ADD, "stray write")
    `ART_ASSERT(a_hold_on_stall, clk, rst_n, (state_reg == ST_PROC && act.emit && !out_free) |=> (state_reg == ST_PROC), "walk moved on stall")

endmodule
